### sv/rmps_pkg.sv
// Shared types and constants for the rigid matrix-palette skinning block.
// No dependencies; imported by rmps_column and rigid_matrix_palette_skinning.
`default_nettype none

package rmps_pkg;

    localparam int WORD_W         = 32;
    localparam int WORDS_PER_BONE = 12;
    localparam int COLS           = 3;
    localparam int TRANS_BASE     = 9;

    typedef enum logic [0:0] {
        CMD_LOAD   = 1'b0,
        CMD_VERTEX = 1'b1
    } cmd_t;

    // Per-stage advance enables for the arithmetic stages.
    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
    } stage_en_t;

endpackage

`default_nettype wire

### sv/rmps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; one instance per matrix word holds every bone's copy of it.
`default_nettype none

module rmps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/rmps_column.sv
// One output column: three products, floor shift, exact sum with translation,
// saturation to 32 bits. Depends on rmps_pkg for word width and stage enables.
`default_nettype none

module rmps_column #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire rmps_pkg::stage_en_t           stage_en,
    input  wire logic                          bone_ok,
    input  wire logic signed [rmps_pkg::WORD_W-1:0] pos_x,
    input  wire logic signed [rmps_pkg::WORD_W-1:0] pos_y,
    input  wire logic signed [rmps_pkg::WORD_W-1:0] pos_z,
    input  wire logic signed [rmps_pkg::WORD_W-1:0] m_x,
    input  wire logic signed [rmps_pkg::WORD_W-1:0] m_y,
    input  wire logic signed [rmps_pkg::WORD_W-1:0] m_z,
    input  wire logic signed [rmps_pkg::WORD_W-1:0] trans,
    output logic      signed [rmps_pkg::WORD_W-1:0] result
);

    import rmps_pkg::*;

    localparam int PROD_W = 2 * WORD_W;
    localparam int SH_W   = PROD_W - FRAC_BITS;
    localparam int SUM_W  = SH_W + 2;

    localparam logic signed [SUM_W-1:0] MAX_V =
        {{(SUM_W - WORD_W + 1){1'b0}}, {(WORD_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] MIN_V = ~MAX_V;

    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [WORD_W-1:0] trans_reg;
    logic                     ok2_reg;
    logic signed [SH_W-1:0]   sh_x, sh_y, sh_z;
    logic signed [SUM_W-1:0]  sum_next, sum_reg;
    logic                     ok3_reg;
    logic signed [WORD_W-1:0] result_next, result_reg;

    // Arithmetic shift rounds the product toward minus infinity.
    assign sh_x = SH_W'(prod_x_reg >>> FRAC_BITS);
    assign sh_y = SH_W'(prod_y_reg >>> FRAC_BITS);
    assign sh_z = SH_W'(prod_z_reg >>> FRAC_BITS);

    assign sum_next = SUM_W'(sh_x) + SUM_W'(sh_y) + SUM_W'(sh_z) + SUM_W'(trans_reg);

    always_comb begin
        if (!ok3_reg) begin
            result_next = '0;
        end else if (sum_reg > MAX_V) begin
            result_next = MAX_V[WORD_W-1:0];
        end else if (sum_reg < MIN_V) begin
            result_next = MIN_V[WORD_W-1:0];
        end else begin
            result_next = sum_reg[WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.en2) begin
            prod_x_reg <= pos_x * m_x;
            prod_y_reg <= pos_y * m_y;
            prod_z_reg <= pos_z * m_z;
            trans_reg  <= trans;
            ok2_reg    <= bone_ok;
        end
        if (stage_en.en3) begin
            sum_reg <= sum_next;
            ok3_reg <= ok2_reg;
        end
        if (stage_en.en4) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

### sv/rigid_matrix_palette_skinning.sv
// Rigid matrix-palette skinning, top level.
// Depends on rmps_pkg, rmps_ram (twelve word banks) and rmps_column (three columns).
//
// Usage: one input stream (s_t*) carries two kinds of word, picked by s_tuser.
// A load word (CMD_LOAD) writes one Q16.16 word of one bone's 4x3 matrix;
// a vertex word (CMD_VERTEX) transforms (x, y, z) by its own bone's matrix and
// yields one result word on m_t*: out_x, out_y, out_z, each saturated Q16.16.
// Load words give no result; a load with a bone or word index out of range is
// dropped, and a vertex with a bone out of range returns all zeros.
// Pipeline: the palette read is registered as a vertex is accepted, then come
// products, sum, and saturation into the output register that drives m_tvalid.
// Throughput: one word per cycle while s_tready is high, loads and vertices
// mixed freely; a load is seen by a vertex accepted in the very next cycle.
// The palette is twelve banks, one per matrix word, so a vertex reads all of
// its matrix in one access.
// Reset clears only the pipeline valid bits; palette contents stay undefined
// until written and no clearing pass runs. When m_tready is low the stages hold,
// empty stages still fill, and s_tready drops once all four stages are full.
`default_nettype none

module rigid_matrix_palette_skinning #(
    parameter int BONE_COUNT = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [4:0] bone_index, [8:5] word_index, [40:9] word_value,
    // [72:41] pos_x, [104:73] pos_y, [136:105] pos_z, [143:137] zero
    input  wire logic [143:0] s_tdata,
    // [0] command
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z
    output logic [95:0]       m_tdata
);

    import rmps_pkg::*;

    localparam int ADDR_W = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

    logic [4:0]               bone_index;
    logic [3:0]               word_index;
    logic [WORD_W-1:0]        word_value;
    logic signed [WORD_W-1:0] pos_x, pos_y, pos_z;
    logic [7:0]               bone_wide;
    logic [ADDR_W-1:0]        bone_addr;
    logic                     bone_ok;
    logic                     accept, is_vertex, is_load;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic                     en1, en2, en3, en4;
    stage_en_t                stage_en;

    logic signed [WORD_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic                     ok1_reg;
    logic [WORD_W-1:0]        bank_rdata [WORDS_PER_BONE];
    logic signed [WORD_W-1:0] col_result [COLS];

    assign bone_index = s_tdata[4:0];
    assign word_index = s_tdata[8:5];
    assign word_value = s_tdata[40:9];
    assign pos_x      = s_tdata[72:41];
    assign pos_y      = s_tdata[104:73];
    assign pos_z      = s_tdata[136:105];

    assign bone_wide = {3'b000, bone_index};
    assign bone_addr = bone_wide[ADDR_W-1:0];
    assign bone_ok   = {1'b0, bone_wide} < 9'(BONE_COUNT);

    // Each stage advances when empty or when the stage after it advances.
    assign en4 = !v4_reg || m_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign stage_en.en2 = en2;
    assign stage_en.en3 = en3;
    assign stage_en.en4 = en4;

    assign s_tready  = en1 && aresetn;
    assign accept    = s_tvalid && s_tready;
    assign is_vertex = s_tuser == CMD_VERTEX;
    assign is_load   = s_tuser == CMD_LOAD;

    genvar gw;
    generate
        for (gw = 0; gw < WORDS_PER_BONE; gw++) begin : g_bank
            rmps_ram #(
                .WIDTH (WORD_W),
                .DEPTH (BONE_COUNT)
            ) u_bank (
                .aclk  (aclk),
                .we    (accept && is_load && bone_ok && (word_index == 4'(gw))),
                .waddr (bone_addr),
                .wdata (word_value),
                .re    (en1),
                .raddr (bone_addr),
                .rdata (bank_rdata[gw])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= accept && is_vertex;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // Stage 1 payload lines up with the registered bank read.
    always_ff @(posedge aclk) begin
        if (en1) begin
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
            pos_z_reg <= pos_z;
            ok1_reg   <= bone_ok;
        end
    end

    genvar gc;
    generate
        for (gc = 0; gc < COLS; gc++) begin : g_col
            rmps_column #(
                .FRAC_BITS (FRAC_BITS)
            ) u_column (
                .aclk     (aclk),
                .stage_en (stage_en),
                .bone_ok  (ok1_reg),
                .pos_x    (pos_x_reg),
                .pos_y    (pos_y_reg),
                .pos_z    (pos_z_reg),
                .m_x      (bank_rdata[gc]),
                .m_y      (bank_rdata[COLS + gc]),
                .m_z      (bank_rdata[2 * COLS + gc]),
                .trans    (bank_rdata[TRANS_BASE + gc]),
                .result   (col_result[gc])
            );
        end
    endgenerate

    assign m_tvalid = v4_reg;
    assign m_tdata  = {col_result[2], col_result[1], col_result[0]};

    a_vertex_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_vertex |=> v1_reg)
        else $error("accepted vertex did not enter stage 1");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_load |=> !v1_reg)
        else $error("load word started a result");

    a_full_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && v2_reg && v3_reg && v4_reg && !m_tready |-> !s_tready)
        else $error("input accepted while the pipeline is full and stalled");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !v3_reg |=> !m_tvalid)
        else $error("result repeated after it was taken");

    a_bubble_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        !v4_reg && v3_reg |=> v4_reg)
        else $error("empty output stage did not take a waiting result");

endmodule

`default_nettype wire
